// ===== src/sip_pkg.sv =====
// Shared constants, types and state encoding for the string intern pool.
package sip_pkg;

  localparam int POOL_BYTES = 4096;
  localparam int MAX_STRING = 64;

  localparam int ADDR_W  = $clog2(POOL_BYTES);
  localparam int FILL_W  = $clog2(POOL_BYTES + 1);
  localparam int LEN_W   = $clog2(MAX_STRING + 1);
  localparam int NCELL   = MAX_STRING + 1;
  localparam int VALUE_W = 12;
  localparam int IN_ADDR_W = 12;

  typedef logic [7:0]           char_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [VALUE_W-1:0]   value_t;
  typedef logic [IN_ADDR_W-1:0] in_addr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_APPEND,
    S_EMIT
  } state_t;

  // Controls broadcast to every cell of the match row.
  typedef struct packed {
    logic  clear;
    logic  step;
    logic  shift;
    char_t pool_byte;
  } cell_ctrl_t;

endpackage

// ===== src/sip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sip_cell.sv =====
// One match cell: holds a pending character and a partial-match bit.
module sip_cell (
  input  logic               clk,
  input  sip_pkg::cell_ctrl_t ctrl,
  input  logic               load,
  input  sip_pkg::char_t     load_char,
  input  logic               is_term,
  input  sip_pkg::char_t     shift_in,
  input  logic               m_in,
  output sip_pkg::char_t     ch,
  output logic               m
);
  import sip_pkg::*;

  logic eq;

  // The cell at the string length matches the terminator instead.
  assign eq = is_term ? (ctrl.pool_byte == 8'd0) : (ctrl.pool_byte == ch);

  always_ff @(posedge clk) begin
    if (load) begin
      ch <= load_char;
    end else if (ctrl.shift) begin
      ch <= shift_in;
    end
    if (ctrl.clear) begin
      m <= 1'b0;
    end else if (ctrl.step) begin
      m <= m_in & eq;
    end
  end

endmodule

// ===== src/string_intern_pool.sv =====
// Top level of the string intern pool: control, pool memory and match row.
//
//   channel | direction | fields                       | handshake
//   in      | input     | func, char_in, address       | in_valid / in_ready
//   out     | output    | kind, value, found, overflow | out_valid / out_ready
//
// A character push is stored in the match row; a read-back goes through the read and emit states.
// A string end scans the pool one byte a cycle through the pool RAM read port;
// on a miss it then appends the string and its zero terminator.
// Reset sets the fill level to 1 and clears the pending length; pool bytes need no clearing.
// Input stalls while a read-back, search, append or result hand-off is in progress;
// a result waiting at the output does not block the next item.
module string_intern_pool (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  sip_pkg::char_t    char_in,
  input  sip_pkg::in_addr_t address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output sip_pkg::value_t   value,
  output logic              found,
  output logic              overflow
);
  import sip_pkg::*;

  state_t state, state_next;
  fill_t  fill;
  len_t   len;
  logic   too_long;
  fill_t  scan_addr;
  logic   v1, v2;
  fill_t  a1, a2;
  fill_t  wr_ptr;
  len_t   wr_cnt;
  logic   rd_ok;
  logic   res_kind, res_found, res_ovf;
  value_t res_value;

  logic   accept, push, start_str, scan_issue, hit, last, miss, room_ok;
  logic   out_load, clr_pend;
  char_t  rdata, wdata;
  addr_t  raddr;
  cell_ctrl_t ctrl;
  char_t  ch [NCELL];
  logic   m  [NCELL];

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign push      = accept & ~func & (char_in != 8'd0);
  assign start_str = accept & ~func & (char_in == 8'd0);
  assign scan_issue = (state == S_SCAN) && (scan_addr < fill);
  assign hit  = (state == S_SCAN) && v2 && m[len];
  assign last = (state == S_SCAN) && v2 && (a2 == fill - FILL_W'(1));
  assign miss = (start_str && !too_long && len != '0 && fill == FILL_W'(1)) ||
                (last && !hit);
  assign room_ok = (32'(fill) + 32'(len) + 32'd1) <= 32'(POOL_BYTES);
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && func) begin
          state_next = S_READ;
        end else if (start_str) begin
          if (too_long || len == '0) begin
            state_next = S_EMIT;
          end else if (miss) begin
            state_next = room_ok ? S_APPEND : S_EMIT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_READ: state_next = S_EMIT;
      S_SCAN: begin
        if (hit) begin
          state_next = S_EMIT;
        end else if (miss) begin
          state_next = room_ok ? S_APPEND : S_EMIT;
        end
      end
      S_APPEND: begin
        if (wr_cnt == len) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Drop the pending string when an intern operation moves on to the emit state.
  assign clr_pend = (state_next == S_EMIT) && (state != S_READ) && (state != S_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= FILL_W'(1);
      len       <= '0;
      too_long  <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= scan_issue;
      v2 <= v1;
      if (push) begin
        if (32'(len) < 32'(MAX_STRING)) begin
          len <= len + LEN_W'(1);
        end else begin
          too_long <= 1'b1;
        end
      end
      if (clr_pend) begin
        len      <= '0;
        too_long <= 1'b0;
      end
      if (state == S_APPEND && wr_cnt == len) begin
        fill <= wr_ptr + FILL_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a1 <= scan_addr;
    a2 <= a1;
    if (scan_issue) begin
      scan_addr <= scan_addr + FILL_W'(1);
    end
    if (start_str) begin
      scan_addr <= FILL_W'(1);
    end
    if (accept && func) begin
      rd_ok <= (32'(address) < 32'(fill)) && (address != '0);
    end
    if (state == S_APPEND) begin
      wr_ptr <= wr_ptr + FILL_W'(1);
      wr_cnt <= wr_cnt + LEN_W'(1);
    end
    if (miss && room_ok) begin
      wr_ptr <= fill;
      wr_cnt <= '0;
    end
    // Stage the result for the output register.
    if (state == S_READ) begin
      res_kind  <= 1'b1;
      res_value <= rd_ok ? VALUE_W'(rdata) : '0;
      res_found <= 1'b0;
      res_ovf   <= 1'b0;
    end else if (start_str && (too_long || len == '0)) begin
      res_kind  <= 1'b0;
      res_value <= '0;
      res_found <= !too_long;
      res_ovf   <= too_long;
    end else if (hit) begin
      res_kind  <= 1'b0;
      res_value <= VALUE_W'(a2 - FILL_W'(len));
      res_found <= 1'b1;
      res_ovf   <= 1'b0;
    end else if (miss) begin
      res_kind  <= 1'b0;
      res_value <= room_ok ? VALUE_W'(fill) : '0;
      res_found <= 1'b0;
      res_ovf   <= !room_ok;
    end
    if (out_load) begin
      kind     <= res_kind;
      value    <= res_value;
      found    <= res_found;
      overflow <= res_ovf;
    end
  end

  assign raddr = (state == S_SCAN) ? addr_t'(scan_addr) : addr_t'(address);
  assign wdata = (wr_cnt == len) ? 8'd0 : ch[0];

  sip_ram #(
    .WIDTH (8),
    .DEPTH (POOL_BYTES)
  ) u_pool (
    .clk   (clk),
    .we    (state == S_APPEND),
    .waddr (addr_t'(wr_ptr)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ctrl.clear     = start_str;
  assign ctrl.step      = v1;
  assign ctrl.shift     = (state == S_APPEND);
  assign ctrl.pool_byte = rdata;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sip_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load      (push && len == LEN_W'(k)),
      .load_char (char_in),
      .is_term   (len == LEN_W'(k)),
      .shift_in  ((k == NCELL - 1) ? 8'd0 : ch[(k + 1) % NCELL]),
      .m_in      ((k == 0) ? 1'b1 : m[(k + NCELL - 1) % NCELL]),
      .ch        (ch[k]),
      .m         (m[k])
    );
  end

  a_fill_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> fill >= $past(fill))
    else $error("fill level went backward");

  a_len_max: assert property (@(posedge clk) disable iff (rst)
    32'(len) <= 32'(MAX_STRING))
    else $error("pending length beyond buffer");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    state == S_APPEND |-> 32'(wr_ptr) < 32'(POOL_BYTES))
    else $error("append beyond pool");

  a_scan_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> len != '0 && !too_long)
    else $error("scan without a valid pending string");

endmodule
